>>> hdl/gdos_pkg.sv
// Shared types, widths, calendar tables and codes of the Gregorian date core.
package gdos_pkg;

   // Field widths of the request and response.
   localparam int YEAR_BITS   = 16;
   localparam int OFFSET_BITS = 21;
   localparam int MONTH_BITS  = 4;
   localparam int DAY_BITS    = 5;
   localparam int DOY_BITS    = 9;
   localparam int COUNT_BITS  = 25;

   localparam int IN_FIELD_BITS = 2 * YEAR_BITS + 2 * MONTH_BITS + 2 * DAY_BITS + OFFSET_BITS;
   localparam int IN_DATA_BITS  = ((IN_FIELD_BITS + 7) / 8) * 8;

   // Calendar constants.
   localparam int ERA_YEARS = 400;
   localparam int ERA_DAYS  = 146097;
   localparam int CENT_DAYS = 36524;
   localparam int QUAD_DAYS = 1461;
   localparam int YEAR_DAYS = 365;

   // Era bias keeps every biased year and biased day number non-negative.
   localparam int ERA_BIAS = ((2 ** (YEAR_BITS - 1)) + (2 ** (OFFSET_BITS - 1)) / YEAR_DAYS)
                             / ERA_YEARS + 2;

   // Internal widths.
   localparam int YB_W   = YEAR_BITS + 1;    // biased March-based year
   localparam int ERA_W  = YB_W - 8;         // biased era of a year
   localparam int DW     = YEAR_BITS + 10;   // biased day number
   localparam int ZQ_W   = DW - 17;          // biased era of a day number
   localparam int DV_W   = 18;               // divisor and remainder
   localparam int RCP_W  = 18;               // reciprocal and quotient estimate
   localparam int YOE_W  = 9;                // year within era, 0..400
   localparam int DOE_W  = 18;               // day within era
   localparam int QN_W   = 16;               // day within century
   localparam int Q4_W   = 5;                // four-year block within century
   localparam int R4_W   = 11;               // day within four-year block
   localparam int YW     = ZQ_W + 11;        // signed result year before range check

   // Operation codes carried in tuser.
   localparam logic OP_SHIFT = 1'b0;
   localparam logic OP_COUNT = 1'b1;

   typedef struct packed {
      logic                   op;
      logic                   bad;
      logic [OFFSET_BITS-1:0] offset;
      logic [YB_W-1:0]        s_yb;
      logic [DOY_BITS-1:0]    s_doy;
      logic                   s_feb29;
      logic [YB_W-1:0]        e_yb;
      logic [DOY_BITS-1:0]    e_doy;
      logic                   e_feb29;
   } entry_type;

   typedef struct packed {
      logic                   bad_input;
      logic                   event_passed;
      logic [COUNT_BITS-1:0]  day_count;
      logic                   leap_year;
      logic [DOY_BITS-1:0]    day_of_year;
      logic [DAY_BITS-1:0]    res_day;
      logic [MONTH_BITS-1:0]  res_month;
      logic [YEAR_BITS-1:0]   res_year;
   } res_type;

   localparam int OUT_DATA_BITS = (($bits(res_type) + 7) / 8) * 8;

   typedef struct packed {
      logic start;
   } div_ctrl_type;

   // Days from March 1 to the first of a civil month.
   function automatic logic [DOY_BITS-1:0] mar_start(input logic [MONTH_BITS-1:0] m);
      logic [DOY_BITS-1:0] v;
      case (m)
         4'd1:    v = 9'd306;
         4'd2:    v = 9'd337;
         4'd3:    v = 9'd0;
         4'd4:    v = 9'd31;
         4'd5:    v = 9'd61;
         4'd6:    v = 9'd92;
         4'd7:    v = 9'd122;
         4'd8:    v = 9'd153;
         4'd9:    v = 9'd184;
         4'd10:   v = 9'd214;
         4'd11:   v = 9'd245;
         4'd12:   v = 9'd275;
         default: v = 9'd0;
      endcase
      return v;
   endfunction

   // Days from March 1 to the first of a March-based month index.
   function automatic logic [DOY_BITS-1:0] mar_mstart(input logic [3:0] mp);
      logic [DOY_BITS-1:0] v;
      case (mp)
         4'd0:    v = 9'd0;
         4'd1:    v = 9'd31;
         4'd2:    v = 9'd61;
         4'd3:    v = 9'd92;
         4'd4:    v = 9'd122;
         4'd5:    v = 9'd153;
         4'd6:    v = 9'd184;
         4'd7:    v = 9'd214;
         4'd8:    v = 9'd245;
         4'd9:    v = 9'd275;
         4'd10:   v = 9'd306;
         4'd11:   v = 9'd337;
         default: v = 9'd0;
      endcase
      return v;
   endfunction

   // Days from January 1 to the first of a civil month in a common year.
   function automatic logic [DOY_BITS-1:0] civ_start(input logic [MONTH_BITS-1:0] m);
      logic [DOY_BITS-1:0] v;
      case (m)
         4'd1:    v = 9'd0;
         4'd2:    v = 9'd31;
         4'd3:    v = 9'd59;
         4'd4:    v = 9'd90;
         4'd5:    v = 9'd120;
         4'd6:    v = 9'd151;
         4'd7:    v = 9'd181;
         4'd8:    v = 9'd212;
         4'd9:    v = 9'd243;
         4'd10:   v = 9'd273;
         4'd11:   v = 9'd304;
         4'd12:   v = 9'd334;
         default: v = 9'd0;
      endcase
      return v;
   endfunction

   // Longest possible length of a month; February is checked later for leap years.
   function automatic logic [DAY_BITS-1:0] month_max(input logic [MONTH_BITS-1:0] m);
      logic [DAY_BITS-1:0] v;
      case (m)
         4'd2:                    v = 5'd29;
         4'd4, 4'd6, 4'd9, 4'd11: v = 5'd30;
         default:                 v = 5'd31;
      endcase
      return v;
   endfunction

   // Leap test on a year taken modulo 400, given as 0..400.
   function automatic logic leap_mod400(input logic [YOE_W-1:0] v);
      return (v[1:0] == 2'b00) && (v != YOE_W'(100)) && (v != YOE_W'(200))
             && (v != YOE_W'(300));
   endfunction

endpackage

>>> hdl/gdos_div.sv
// Constant divider by reciprocal multiplication, shared by the back end.
module gdos_div (
   input  logic                      clock,
   input  logic                      reset,
   input  gdos_pkg::div_ctrl_type    ctrl,
   input  logic [gdos_pkg::DW-1:0]   num,
   input  logic [gdos_pkg::DV_W-1:0] divisor,
   output logic                      done,
   output logic [gdos_pkg::DW-1:0]   quot,
   output logic [gdos_pkg::DV_W-1:0] rem
);
   import gdos_pkg::*;

   logic                est_ff, est_in;
   logic                sub_ff, sub_in;
   logic                fix_ff, fix_in;
   logic                done_ff, done_in;
   logic [DW-1:0]       num_ff, num_in;
   logic [DV_W-1:0]     div_ff, div_in;
   logic [RCP_W-1:0]    rcp_ff, rcp_in;
   logic [RCP_W-1:0]    qe_ff, qe_in;
   logic [DW-1:0]       re_ff, re_in;
   logic [DW-1:0]       quot_ff, quot_in;
   logic [DV_W-1:0]     rem_ff, rem_in;
   logic [DW+RCP_W-1:0] prod;
   logic [DW-1:0]       qd;

   // Reciprocal scaled by 2 to the power DW, rounded down.
   function automatic logic [RCP_W-1:0] recip(input logic [DV_W-1:0] d);
      logic [RCP_W-1:0] v;
      case (d)
         DV_W'(ERA_YEARS): v = RCP_W'((2 ** DW) / ERA_YEARS);
         DV_W'(ERA_DAYS):  v = RCP_W'((2 ** DW) / ERA_DAYS);
         DV_W'(QUAD_DAYS): v = RCP_W'((2 ** DW) / QUAD_DAYS);
         default:          v = '0;
      endcase
      return v;
   endfunction

   // Estimate the quotient, form the remainder, then correct by at most one.
   always_comb begin
      est_in  = ctrl.start;
      sub_in  = est_ff;
      fix_in  = sub_ff;
      done_in = fix_ff;
      num_in  = num_ff;
      div_in  = div_ff;
      rcp_in  = rcp_ff;
      qe_in   = qe_ff;
      re_in   = re_ff;
      quot_in = quot_ff;
      rem_in  = rem_ff;
      prod    = (DW + RCP_W)'(num_ff) * (DW + RCP_W)'(rcp_ff);
      qd      = DW'(qe_ff) * DW'(div_ff);
      if (ctrl.start) begin
         num_in = num;
         div_in = divisor;
         rcp_in = recip(divisor);
      end
      if (est_ff) begin
         qe_in = prod[DW+RCP_W-1:DW];
      end
      if (sub_ff) begin
         re_in = num_ff - qd;
      end
      if (fix_ff) begin
         if (re_ff >= DW'(div_ff)) begin
            quot_in = DW'(qe_ff) + DW'(1);
            rem_in  = DV_W'(re_ff - DW'(div_ff));
         end else begin
            quot_in = DW'(qe_ff);
            rem_in  = DV_W'(re_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         est_ff  <= 1'b0;
         sub_ff  <= 1'b0;
         fix_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         est_ff  <= est_in;
         sub_ff  <= sub_in;
         fix_ff  <= fix_in;
         done_ff <= done_in;
      end
      num_ff  <= num_in;
      div_ff  <= div_in;
      rcp_ff  <= rcp_in;
      qe_ff   <= qe_in;
      re_ff   <= re_in;
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;
   assign rem  = rem_ff;

endmodule

>>> hdl/gdos_front.sv
// Front end: takes requests, checks the dates and prepares biased years.
module gdos_front (
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [gdos_pkg::IN_DATA_BITS-1:0] req_tdata,
   input  logic                              req_tuser,
   input  logic                              q_full,
   output logic                              q_push,
   output gdos_pkg::entry_type               q_entry
);
   import gdos_pkg::*;

   localparam int SM_LSB = YEAR_BITS;
   localparam int SD_LSB = SM_LSB + MONTH_BITS;
   localparam int OF_LSB = SD_LSB + DAY_BITS;
   localparam int EY_LSB = OF_LSB + OFFSET_BITS;
   localparam int EM_LSB = EY_LSB + YEAR_BITS;
   localparam int ED_LSB = EM_LSB + MONTH_BITS;

   logic [YEAR_BITS-1:0]  sy, ey;
   logic [MONTH_BITS-1:0] sm, em;
   logic [DAY_BITS-1:0]   sd, ed;
   logic                  s_bad, e_bad;

   assign sy = req_tdata[YEAR_BITS-1:0];
   assign sm = req_tdata[SD_LSB-1:SM_LSB];
   assign sd = req_tdata[OF_LSB-1:SD_LSB];
   assign ey = req_tdata[EM_LSB-1:EY_LSB];
   assign em = req_tdata[ED_LSB-1:EM_LSB];
   assign ed = req_tdata[ED_LSB+DAY_BITS-1:ED_LSB];

   // March-based year plus the era bias; the year before for January and February.
   function automatic logic [YB_W-1:0] biased_year(input logic [YEAR_BITS-1:0] y,
                                                   input logic [MONTH_BITS-1:0] m);
      logic [YB_W-1:0] ys;
      ys = {y[YEAR_BITS-1], y} - ((m <= MONTH_BITS'(2)) ? YB_W'(1) : YB_W'(0));
      return ys + YB_W'(ERA_BIAS * ERA_YEARS);
   endfunction

   function automatic logic date_bad(input logic [MONTH_BITS-1:0] m,
                                     input logic [DAY_BITS-1:0] d);
      return (m == '0) || (m > MONTH_BITS'(12)) || (d == '0) || (d > month_max(m));
   endfunction

   // Classification of the request.
   always_comb begin
      s_bad           = date_bad(sm, sd);
      e_bad           = date_bad(em, ed);
      q_entry.op      = req_tuser;
      q_entry.bad     = s_bad || ((req_tuser == OP_COUNT) && e_bad);
      q_entry.offset  = req_tdata[EY_LSB-1:OF_LSB];
      q_entry.s_yb    = biased_year(sy, sm);
      q_entry.s_doy   = mar_start(sm) + DOY_BITS'(sd) - DOY_BITS'(1);
      q_entry.s_feb29 = (sm == MONTH_BITS'(2)) && (sd == DAY_BITS'(29));
      q_entry.e_yb    = biased_year(ey, em);
      q_entry.e_doy   = mar_start(em) + DOY_BITS'(ed) - DOY_BITS'(1);
      q_entry.e_feb29 = (em == MONTH_BITS'(2)) && (ed == DAY_BITS'(29));
   end

   assign req_tready = !q_full;
   assign q_push     = req_tvalid && !q_full;

endmodule

>>> hdl/gdos_queue.sv
// Two-entry queue between the front end and the back end.
module gdos_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  gdos_pkg::entry_type push_entry,
   input  logic                pop,
   output gdos_pkg::entry_type head,
   output logic                full,
   output logic                empty
);
   import gdos_pkg::*;

   entry_type  mem_ff [2];
   logic       wr_ff, wr_in;
   logic       rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;

   // Pointer and fill count update.
   always_comb begin
      wr_in  = push ? !wr_ff : wr_ff;
      rd_in  = pop ? !rd_ff : rd_ff;
      cnt_in = cnt_ff + (push ? 2'd1 : 2'd0) - (pop ? 2'd1 : 2'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wr_ff] <= push_entry;
      end
   end

   assign head  = mem_ff[rd_ff];
   assign full  = (cnt_ff == 2'd2);
   assign empty = (cnt_ff == 2'd0);

endmodule

>>> hdl/gdos_back.sv
// Back end: sequencer that turns dates into day numbers and back, with the response register.
module gdos_back (
   input  logic                               clock,
   input  logic                               reset,
   input  gdos_pkg::entry_type                head,
   input  logic                               empty,
   output logic                               pop,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [gdos_pkg::OUT_DATA_BITS-1:0] rsp_tdata
);
   import gdos_pkg::*;

   typedef enum logic [10:0] {
      ST_IDLE    = 11'b00000000001,
      ST_TD_DIV  = 11'b00000000010,
      ST_TD_MUL  = 11'b00000000100,
      ST_TD_ADD  = 11'b00000001000,
      ST_FD_DIV1 = 11'b00000010000,
      ST_FD_CENT = 11'b00000100000,
      ST_FD_DIV2 = 11'b00001000000,
      ST_FD_YR   = 11'b00010000000,
      ST_FD_MON  = 11'b00100000000,
      ST_FD_YEAR = 11'b01000000000,
      ST_DONE    = 11'b10000000000
   } state_type;

   localparam int PAD_BITS = OUT_DATA_BITS - $bits(res_type);
   localparam logic signed [YW-1:0] Y_MIN = -(YW'(1) <<< (YEAR_BITS - 1));
   localparam logic signed [YW-1:0] Y_MAX = (YW'(1) <<< (YEAR_BITS - 1)) - YW'(1);

   state_type                  state_ff, state_in;
   entry_type                  ent_ff, ent_in;
   logic                       sel_ff, sel_in;
   logic                       err_ff, err_in;
   logic [DW-1:0]              prod_ff, prod_in;
   logic [DOE_W-1:0]           doe_ff, doe_in;
   logic [DW-1:0]              ds_ff, ds_in;
   logic [ZQ_W-1:0]            zq_ff, zq_in;
   logic [YOE_W-1:0]           yoe_ff, yoe_in;
   logic [DOY_BITS-1:0]        doy_ff, doy_in;
   logic [MONTH_BITS-1:0]      mon_ff, mon_in;
   logic [DAY_BITS-1:0]        day_ff, day_in;
   res_type                    res_ff, res_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [OUT_DATA_BITS-1:0]   rsp_data_ff, rsp_data_in;

   div_ctrl_type               div_ctrl;
   logic [DW-1:0]              div_num;
   logic [DV_W-1:0]            div_divisor;
   logic                       div_done;
   logic [DW-1:0]              div_quot;
   logic [DV_W-1:0]            div_rem;

   gdos_div u_div (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (div_ctrl),
      .num     (div_num),
      .divisor (div_divisor),
      .done    (div_done),
      .quot    (div_quot),
      .rem     (div_rem)
   );

   // Working values of the sequencer.
   logic [YOE_W-1:0]          td_yoe;
   logic [DW-1:0]             td_days;
   logic [DW:0]               diff;
   logic [DW-1:0]             z_days;
   logic [DOE_W-1:0]          fd_doe;
   logic [QN_W-1:0]           fd_rem;
   logic [1:0]                fd_cent;
   logic [R4_W-1:0]           fd_r4;
   logic [1:0]                fd_yr;
   logic [3:0]                fd_mp;
   logic                      early;
   logic [YOE_W-1:0]          y400;
   logic signed [ZQ_W:0]      era_s;
   logic signed [YW-1:0]      y_full;
   logic                      leap;

   always_comb begin
      state_in     = state_ff;
      ent_in       = ent_ff;
      sel_in       = sel_ff;
      err_in       = err_ff;
      prod_in      = prod_ff;
      doe_in       = doe_ff;
      ds_in        = ds_ff;
      zq_in        = zq_ff;
      yoe_in       = yoe_ff;
      doy_in       = doy_ff;
      mon_in       = mon_ff;
      day_in       = day_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      pop          = 1'b0;
      div_ctrl     = '0;
      div_num      = '0;
      div_divisor  = '0;

      td_yoe  = div_rem[YOE_W-1:0];
      td_days = prod_ff + DW'(doe_ff);
      diff    = {1'b0, td_days} - {1'b0, ds_ff};
      z_days  = td_days + {{(DW - OFFSET_BITS){ent_ff.offset[OFFSET_BITS-1]}}, ent_ff.offset};

      // Century inside the era, capped at the fourth.
      fd_doe  = div_rem[DOE_W-1:0];
      fd_cent = 2'd0;
      fd_rem  = QN_W'(fd_doe);
      if (fd_doe >= DOE_W'(3 * CENT_DAYS)) begin
         fd_cent = 2'd3;
         fd_rem  = QN_W'(fd_doe - DOE_W'(3 * CENT_DAYS));
      end else if (fd_doe >= DOE_W'(2 * CENT_DAYS)) begin
         fd_cent = 2'd2;
         fd_rem  = QN_W'(fd_doe - DOE_W'(2 * CENT_DAYS));
      end else if (fd_doe >= DOE_W'(CENT_DAYS)) begin
         fd_cent = 2'd1;
         fd_rem  = QN_W'(fd_doe - DOE_W'(CENT_DAYS));
      end

      // Year inside the four-year block, capped at the fourth.
      fd_r4 = div_rem[R4_W-1:0];
      fd_yr = 2'd0;
      if (fd_r4 >= R4_W'(3 * YEAR_DAYS)) begin
         fd_yr = 2'd3;
      end else if (fd_r4 >= R4_W'(2 * YEAR_DAYS)) begin
         fd_yr = 2'd2;
      end else if (fd_r4 >= R4_W'(YEAR_DAYS)) begin
         fd_yr = 2'd1;
      end

      // March-based month from the day within the year.
      fd_mp = 4'd0;
      for (int k = 1; k < 12; k++) begin
         if (doy_ff >= mar_mstart(4'(k))) begin
            fd_mp = 4'(k);
         end
      end

      // Civil year of the shifted date.
      early  = (mon_ff <= MONTH_BITS'(2));
      y400   = yoe_ff + (early ? YOE_W'(1) : YOE_W'(0));
      era_s  = signed'({1'b0, zq_ff}) - (ZQ_W + 1)'(ERA_BIAS);
      y_full = YW'(era_s) * YW'(ERA_YEARS) + signed'(YW'(y400));
      leap   = leap_mod400(y400);

      case (state_ff)
         ST_IDLE: begin
            if (!empty) begin
               pop    = 1'b1;
               ent_in = head;
               sel_in = 1'b0;
               err_in = 1'b0;
               res_in = '0;
               if (head.bad) begin
                  res_in.bad_input = 1'b1;
                  state_in         = ST_DONE;
               end else begin
                  div_ctrl.start = 1'b1;
                  div_num        = DW'(head.s_yb);
                  div_divisor    = DV_W'(ERA_YEARS);
                  state_in       = ST_TD_DIV;
               end
            end
         end
         ST_TD_DIV: begin
            if (div_done) begin
               state_in = ST_TD_MUL;
            end
         end
         ST_TD_MUL: begin
            // Era product and day within the era.
            prod_in = DW'(div_quot[ERA_W-1:0]) * DW'(ERA_DAYS);
            doe_in  = DOE_W'(td_yoe) * DOE_W'(YEAR_DAYS) + DOE_W'(td_yoe >> 2)
                      - ((td_yoe >= YOE_W'(100)) ? DOE_W'(1) : DOE_W'(0))
                      - ((td_yoe >= YOE_W'(200)) ? DOE_W'(1) : DOE_W'(0))
                      - ((td_yoe >= YOE_W'(300)) ? DOE_W'(1) : DOE_W'(0))
                      + DOE_W'(sel_ff ? ent_ff.e_doy : ent_ff.s_doy);
            // February 29 only in a leap year: the civil year is one past the March-based one.
            if ((sel_ff ? ent_ff.e_feb29 : ent_ff.s_feb29)
                && !leap_mod400(td_yoe + YOE_W'(1))) begin
               err_in = 1'b1;
            end
            state_in = ST_TD_ADD;
         end
         ST_TD_ADD: begin
            if (err_ff) begin
               res_in.bad_input = 1'b1;
               state_in         = ST_DONE;
            end else if (sel_ff) begin
               if (diff[DW]) begin
                  res_in.event_passed = 1'b1;
               end else if (diff[DW-1:0] > DW'({COUNT_BITS{1'b1}})) begin
                  res_in.day_count = '1;
               end else begin
                  res_in.day_count = COUNT_BITS'(diff[DW-1:0]);
               end
               state_in = ST_DONE;
            end else if (ent_ff.op == OP_COUNT) begin
               ds_in          = td_days;
               sel_in         = 1'b1;
               div_ctrl.start = 1'b1;
               div_num        = DW'(ent_ff.e_yb);
               div_divisor    = DV_W'(ERA_YEARS);
               state_in       = ST_TD_DIV;
            end else begin
               div_ctrl.start = 1'b1;
               div_num        = z_days;
               div_divisor    = DV_W'(ERA_DAYS);
               state_in       = ST_FD_DIV1;
            end
         end
         ST_FD_DIV1: begin
            if (div_done) begin
               state_in = ST_FD_CENT;
            end
         end
         ST_FD_CENT: begin
            zq_in          = div_quot[ZQ_W-1:0];
            yoe_in         = YOE_W'(fd_cent) * YOE_W'(100);
            div_ctrl.start = 1'b1;
            div_num        = DW'(fd_rem);
            div_divisor    = DV_W'(QUAD_DAYS);
            state_in       = ST_FD_DIV2;
         end
         ST_FD_DIV2: begin
            if (div_done) begin
               state_in = ST_FD_YR;
            end
         end
         ST_FD_YR: begin
            doy_in   = DOY_BITS'(fd_r4 - R4_W'(fd_yr) * R4_W'(YEAR_DAYS));
            yoe_in   = yoe_ff + (YOE_W'(div_quot[Q4_W-1:0]) << 2) + YOE_W'(fd_yr);
            state_in = ST_FD_MON;
         end
         ST_FD_MON: begin
            day_in   = DAY_BITS'(doy_ff - mar_mstart(fd_mp) + DOY_BITS'(1));
            mon_in   = (fd_mp < 4'd10) ? fd_mp + 4'd3 : fd_mp - 4'd9;
            state_in = ST_FD_YEAR;
         end
         ST_FD_YEAR: begin
            if ((y_full < Y_MIN) || (y_full > Y_MAX)) begin
               res_in.bad_input = 1'b1;
            end else begin
               res_in.res_year    = y_full[YEAR_BITS-1:0];
               res_in.res_month   = mon_ff;
               res_in.res_day     = day_ff;
               res_in.leap_year   = leap;
               res_in.day_of_year = civ_start(mon_ff) + DOY_BITS'(day_ff)
                                    + ((!early && leap) ? DOY_BITS'(1) : DOY_BITS'(0));
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // Hand the result over once the response register is free.
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {{PAD_BITS{1'b0}}, res_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ent_ff      <= ent_in;
      sel_ff      <= sel_in;
      err_ff      <= err_in;
      prod_ff     <= prod_in;
      doe_ff      <= doe_in;
      ds_ff       <= ds_in;
      zq_ff       <= zq_in;
      yoe_ff      <= yoe_in;
      doy_ff      <= doy_in;
      mon_ff      <= mon_in;
      day_ff      <= day_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

>>> hdl/gregorian_date_offset_and_span_core.sv
// Top level of the Gregorian date shift and day count core.
//
// Requests arrive on the req_ stream. tuser carries the operation: 0 moves the
// start date by day_offset, 1 counts the days from the start date to the event
// date. Each request gives exactly one response on the rsp_ stream, in order.
// A front end checks the dates and places the request in a two-entry queue, so
// new requests are taken while the back end works and while a response waits.
// The back end runs a sequencer around one shared constant divider that works
// by reciprocal multiplication. Requests are handled one after another: the
// back end takes a new request only once the last result has gone to the
// output register. The response is held in that register; while the receiver
// stalls it stays there, the back end waits with the next result, and the
// queue fills until req_tready drops. Synchronous reset empties the queue,
// returns the sequencer to idle, clears the divider's stage flags and drops
// rsp_tvalid; the data registers are not reset.
module gregorian_date_offset_and_span_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // start_year, start_month, start_day, day_offset, event_year, event_month, event_day
   input  logic [gdos_pkg::IN_DATA_BITS-1:0]  req_tdata,
   // op
   input  logic                               req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // res_year, res_month, res_day, day_of_year, leap_year, day_count, event_passed, bad_input
   output logic [gdos_pkg::OUT_DATA_BITS-1:0] rsp_tdata
);
   import gdos_pkg::*;

   entry_type push_entry;
   entry_type head;
   logic      push;
   logic      pop;
   logic      full;
   logic      empty;

   gdos_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_full     (full),
      .q_push     (push),
      .q_entry    (push_entry)
   );

   gdos_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .full       (full),
      .empty      (empty)
   );

   gdos_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .empty      (empty),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

>>> hdl/gdos_chk.sv
// Port checker of the Gregorian date core and its binding to the top level.
module gdos_chk (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [gdos_pkg::OUT_DATA_BITS-1:0] rsp_tdata
);
   import gdos_pkg::*;

   res_type r;
   assign r = rsp_tdata[$bits(res_type)-1:0];

   // A stalled response holds.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   // A bad request reports nothing else.
   a_bad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && r.bad_input |-> r.res_year == '0 && r.res_month == '0 && r.res_day == '0
         && r.day_of_year == '0 && !r.leap_year && r.day_count == '0 && !r.event_passed)
      else $error("bad_input with other fields set");

   // A passed event gives a zero count and no date.
   a_passed: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && r.event_passed |-> r.day_count == '0 && r.res_month == '0
         && r.day_of_year == '0)
      else $error("event_passed with count or date");

   // A shifted date is a real date with a day of year and no count.
   a_shift: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && r.res_month != '0 |-> r.res_month <= MONTH_BITS'(12) && r.res_day != '0
         && r.day_of_year != '0 && r.day_count == '0 && !r.bad_input)
      else $error("inconsistent shifted date");

   // No response right after reset.
   a_reset: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

endmodule

bind gregorian_date_offset_and_span_core gdos_chk u_gdos_chk (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
